[rtl/g711_pkg.sv]
`default_nettype none

package g711_pkg;

  // Conversion selector carried in tuser
  typedef enum logic [2:0] {
    MODE_PCM_TO_ALAW  = 3'd0,
    MODE_PCM_TO_ULAW  = 3'd1,
    MODE_ALAW_TO_PCM  = 3'd2,
    MODE_ULAW_TO_PCM  = 3'd3,
    MODE_ALAW_TO_ULAW = 3'd4,
    MODE_ULAW_TO_ALAW = 3'd5
  } mode_t;

  localparam int PcmW  = 16;
  localparam int CodeW = 8;

  // Companding constants
  localparam logic [7:0] ULAW_BIAS    = 8'h84;
  localparam logic [8:0] ALAW_SEG_ADD = 9'h108;
  localparam logic [7:0] ALAW_XOR_POS = 8'hD5;
  localparam logic [7:0] ALAW_XOR_NEG = 8'h55;
  localparam logic [7:0] ULAW_XOR_POS = 8'hFF;
  localparam logic [7:0] ULAW_XOR_NEG = 8'h7F;

  // One conversion result
  typedef struct packed {
    logic [CodeW-1:0] code;
    logic [PcmW-1:0]  pcm;
  } g711_res_t;

  // mu-law magnitude index to A-law magnitude index plus one
  localparam logic [7:0] MU_TO_A_TAB [128] = '{
    8'd1, 8'd1, 8'd2, 8'd2, 8'd3, 8'd3, 8'd4, 8'd4,
    8'd5, 8'd5, 8'd6, 8'd6, 8'd7, 8'd7, 8'd8, 8'd8,
    8'd9, 8'd10, 8'd11, 8'd12, 8'd13, 8'd14, 8'd15, 8'd16,
    8'd17, 8'd18, 8'd19, 8'd20, 8'd21, 8'd22, 8'd23, 8'd24,
    8'd25, 8'd27, 8'd29, 8'd31, 8'd33, 8'd34, 8'd35, 8'd36,
    8'd37, 8'd38, 8'd39, 8'd40, 8'd41, 8'd42, 8'd43, 8'd44,
    8'd46, 8'd48, 8'd49, 8'd50, 8'd51, 8'd52, 8'd53, 8'd54,
    8'd55, 8'd56, 8'd57, 8'd58, 8'd59, 8'd60, 8'd61, 8'd62,
    8'd64, 8'd65, 8'd66, 8'd67, 8'd68, 8'd69, 8'd70, 8'd71,
    8'd72, 8'd73, 8'd74, 8'd75, 8'd76, 8'd77, 8'd78, 8'd79,
    8'd81, 8'd82, 8'd83, 8'd84, 8'd85, 8'd86, 8'd87, 8'd88,
    8'd89, 8'd90, 8'd91, 8'd92, 8'd93, 8'd94, 8'd95, 8'd96,
    8'd97, 8'd98, 8'd99, 8'd100, 8'd101, 8'd102, 8'd103, 8'd104,
    8'd105, 8'd106, 8'd107, 8'd108, 8'd109, 8'd110, 8'd111, 8'd112,
    8'd113, 8'd114, 8'd115, 8'd116, 8'd117, 8'd118, 8'd119, 8'd120,
    8'd121, 8'd122, 8'd123, 8'd124, 8'd125, 8'd126, 8'd127, 8'd128
  };

  // A-law magnitude index to mu-law magnitude index
  localparam logic [7:0] A_TO_MU_TAB [128] = '{
    8'd1, 8'd3, 8'd5, 8'd7, 8'd9, 8'd11, 8'd13, 8'd15,
    8'd16, 8'd17, 8'd18, 8'd19, 8'd20, 8'd21, 8'd22, 8'd23,
    8'd24, 8'd25, 8'd26, 8'd27, 8'd28, 8'd29, 8'd30, 8'd31,
    8'd32, 8'd32, 8'd33, 8'd33, 8'd34, 8'd34, 8'd35, 8'd35,
    8'd36, 8'd37, 8'd38, 8'd39, 8'd40, 8'd41, 8'd42, 8'd43,
    8'd44, 8'd45, 8'd46, 8'd47, 8'd48, 8'd48, 8'd49, 8'd49,
    8'd50, 8'd51, 8'd52, 8'd53, 8'd54, 8'd55, 8'd56, 8'd57,
    8'd58, 8'd59, 8'd60, 8'd61, 8'd62, 8'd63, 8'd64, 8'd64,
    8'd65, 8'd66, 8'd67, 8'd68, 8'd69, 8'd70, 8'd71, 8'd72,
    8'd73, 8'd74, 8'd75, 8'd76, 8'd77, 8'd78, 8'd79, 8'd79,
    8'd80, 8'd81, 8'd82, 8'd83, 8'd84, 8'd85, 8'd86, 8'd87,
    8'd88, 8'd89, 8'd90, 8'd91, 8'd92, 8'd93, 8'd94, 8'd95,
    8'd96, 8'd97, 8'd98, 8'd99, 8'd100, 8'd101, 8'd102, 8'd103,
    8'd104, 8'd105, 8'd106, 8'd107, 8'd108, 8'd109, 8'd110, 8'd111,
    8'd112, 8'd113, 8'd114, 8'd115, 8'd116, 8'd117, 8'd118, 8'd119,
    8'd120, 8'd121, 8'd122, 8'd123, 8'd124, 8'd125, 8'd126, 8'd127
  };

endpackage

`default_nettype wire

[rtl/g711_alaw_ulaw_codec_core.sv]
`default_nettype none

// G.711 codec core. Each transaction on the input stream carries a mode in
// in_tuser and either a 16-bit linear sample or a companded byte in in_tdata,
// and yields exactly one result transaction: the A-law or mu-law byte for
// encode and transcode modes, or the 16-bit linear sample for decode modes,
// with the unused field zero (modes 6 and 7 give all zeros). The block keeps
// no state between samples. A sample passes an input register and a result
// register with the conversion logic between them, and one sample is accepted
// every cycle while the output side is ready; a stall on out_tready holds the
// result stage and a full input stage, and then back-pressures in_tready.

module g711_alaw_ulaw_codec_core
  import g711_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [15:0] pcm_sample, [23:16] code_in
  input  wire logic [2:0]  in_tuser,   // [2:0] mode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [23:0] out_tdata   // [7:0] code_out, [23:8] pcm_out
);

  logic             s1_valid_r;
  logic [2:0]       s1_mode_r;
  logic [PcmW-1:0]  s1_pcm_r;
  logic [CodeW-1:0] s1_code_r;
  logic             out_valid_r;
  g711_res_t        out_res_r;
  g711_res_t        res_nxt;
  logic             out_free;
  logic [CodeW-1:0] alaw_code;
  logic [CodeW-1:0] ulaw_code;
  logic [PcmW-1:0]  alaw_pcm;
  logic [PcmW-1:0]  ulaw_pcm;
  logic [CodeW-1:0] a2u_code;
  logic [CodeW-1:0] u2a_code;

  // Stage handshake: a stage moves when the one after it has room
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_mode_r <= in_tuser;
      s1_pcm_r  <= in_tdata[15:0];
      s1_code_r <= in_tdata[23:16];
    end
  end

  g711_enc u_enc (
    .pcm_sample (s1_pcm_r),
    .alaw_code  (alaw_code),
    .ulaw_code  (ulaw_code)
  );

  g711_dec u_dec (
    .code_in  (s1_code_r),
    .alaw_pcm (alaw_pcm),
    .ulaw_pcm (ulaw_pcm)
  );

  g711_xcode u_xcode (
    .code_in  (s1_code_r),
    .a2u_code (a2u_code),
    .u2a_code (u2a_code)
  );

  // Select the conversion for this mode, zero the unused field
  always_comb begin
    res_nxt = '0;
    case (s1_mode_r)
      MODE_PCM_TO_ALAW:  res_nxt.code = alaw_code;
      MODE_PCM_TO_ULAW:  res_nxt.code = ulaw_code;
      MODE_ALAW_TO_PCM:  res_nxt.pcm  = alaw_pcm;
      MODE_ULAW_TO_PCM:  res_nxt.pcm  = ulaw_pcm;
      MODE_ALAW_TO_ULAW: res_nxt.code = a2u_code;
      MODE_ULAW_TO_ALAW: res_nxt.code = u2a_code;
      default:           res_nxt      = '0;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid_r) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.pcm, out_res_r.code};

  // A result never carries both a byte and a linear sample
  a_one_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.code == '0 || out_res_r.pcm == '0))
    else $error("result carries both code and pcm");

  // A held input stage keeps its sample while the result side is blocked
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_free) |=> (s1_valid_r && $stable(s1_pcm_r)
      && $stable(s1_code_r) && $stable(s1_mode_r)))
    else $error("input stage lost a stalled sample");

  // A new result only appears when the input stage held a sample
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_free && !s1_valid_r) |=> !out_valid_r)
    else $error("result produced without a sample");

endmodule

`default_nettype wire

[rtl/g711_enc.sv]
`default_nettype none

module g711_enc
  import g711_pkg::*;
(
  input  wire logic [PcmW-1:0]  pcm_sample,
  output logic      [CodeW-1:0] alaw_code,
  output logic      [CodeW-1:0] ulaw_code
);

  logic [14:0] a_mag;
  logic [2:0]  a_seg;
  logic [3:0]  a_sh;
  logic [3:0]  a_q;
  logic [7:0]  a_mask;
  logic [15:0] u_abs;
  logic [15:0] u_mag;
  logic [2:0]  u_seg;
  logic [3:0]  u_sh;
  logic [3:0]  u_q;
  logic [7:0]  u_mask;

  // A-law: magnitude is x or -x-1, segment from the highest set bit above bit 7
  always_comb begin
    a_mag  = pcm_sample[15] ? ~pcm_sample[14:0] : pcm_sample[14:0];
    a_mask = pcm_sample[15] ? ALAW_XOR_NEG : ALAW_XOR_POS;
    a_seg  = 3'd0;
    for (int i = 0; i < 7; i++) begin
      if (a_mag[8+i]) begin
        a_seg = 3'(i + 1);
      end
    end
    a_sh      = (a_seg < 3'd2) ? 4'd4 : ({1'b0, a_seg} + 4'd3);
    a_q       = 4'(a_mag >> a_sh);
    alaw_code = {1'b0, a_seg, a_q} ^ a_mask;
  end

  // mu-law: biased magnitude, saturate when it runs past the top segment
  always_comb begin
    u_abs  = pcm_sample[15] ? (16'd0 - pcm_sample) : pcm_sample;
    u_mag  = u_abs + {8'd0, ULAW_BIAS};
    u_mask = pcm_sample[15] ? ULAW_XOR_NEG : ULAW_XOR_POS;
    u_seg  = 3'd0;
    for (int i = 0; i < 7; i++) begin
      if (u_mag[8+i]) begin
        u_seg = 3'(i + 1);
      end
    end
    u_sh = {1'b0, u_seg} + 4'd3;
    u_q  = 4'(u_mag >> u_sh);
    if (u_mag[15]) begin
      ulaw_code = ULAW_XOR_NEG ^ u_mask;
    end else begin
      ulaw_code = {1'b0, u_seg, u_q} ^ u_mask;
    end
  end

endmodule

`default_nettype wire

[rtl/g711_dec.sv]
`default_nettype none

module g711_dec
  import g711_pkg::*;
(
  input  wire logic [CodeW-1:0] code_in,
  output logic      [PcmW-1:0]  alaw_pcm,
  output logic      [PcmW-1:0]  ulaw_pcm
);

  logic [7:0]  a_val;
  logic [8:0]  a_sum;
  logic [14:0] a_t;
  logic [7:0]  u_val;
  logic [7:0]  u_base;
  logic [14:0] u_t;

  // A-law: undo even-bit inversion, rebuild mantissa, shift by segment
  always_comb begin
    a_val = code_in ^ ALAW_XOR_NEG;
    a_sum = {1'b0, a_val[3:0], 4'b0000} + ALAW_SEG_ADD;
    if (a_val[6:4] == 3'd0) begin
      a_t = {7'd0, a_val[3:0], 4'b1000};
    end else begin
      a_t = 15'(a_sum) << (a_val[6:4] - 3'd1);
    end
    alaw_pcm = a_val[7] ? {1'b0, a_t} : (16'd0 - {1'b0, a_t});
  end

  // mu-law: invert, add bias, shift by segment, remove bias
  always_comb begin
    u_val  = ~code_in;
    u_base = {1'b0, u_val[3:0], 3'b000} + ULAW_BIAS;
    u_t    = 15'(u_base) << u_val[6:4];
    ulaw_pcm = u_val[7] ? ({8'd0, ULAW_BIAS} - {1'b0, u_t})
                        : ({1'b0, u_t} - {8'd0, ULAW_BIAS});
  end

endmodule

`default_nettype wire

[rtl/g711_xcode.sv]
`default_nettype none

module g711_xcode
  import g711_pkg::*;
(
  input  wire logic [CodeW-1:0] code_in,
  output logic      [CodeW-1:0] a2u_code,
  output logic      [CodeW-1:0] u2a_code
);

  logic [6:0] a_idx;
  logic [6:0] a_ent;
  logic [6:0] u_idx;
  logic [7:0] u_ent;
  logic [6:0] u_val;

  // A-law to mu-law: sign bit passes, magnitude index goes through the table
  always_comb begin
    a_idx    = code_in[6:0] ^ ALAW_XOR_NEG[6:0];
    a_ent    = 7'(A_TO_MU_TAB[a_idx]);
    a2u_code = {code_in[7], ~a_ent};
  end

  // mu-law to A-law: table holds index plus one
  always_comb begin
    u_idx    = ~code_in[6:0];
    u_ent    = MU_TO_A_TAB[u_idx];
    u_val    = 7'(u_ent - 8'd1);
    u2a_code = {code_in[7], u_val ^ ALAW_XOR_NEG[6:0]};
  end

endmodule

`default_nettype wire
